// ===== src/fct_pkg.sv =====
// Shared types, constants and codes of the floor and ceiling texel caster.
package fct_pkg;

	localparam int SCREEN_WIDTH_DEF  = 640;
	localparam int SCREEN_HEIGHT_DEF = 480;
	localparam int TEX_SIZE_DEF      = 64;

	localparam int FRAC_W  = 16;
	localparam int WORLD_W = 40;
	localparam int OFS_W   = 14;
	localparam int DIST_W  = 30;
	localparam int DVD_W   = 34;
	localparam int DVS_W   = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X      = 3'd0,
		REG_POS_Y      = 3'd1,
		REG_DIR_X      = 3'd2,
		REG_DIR_Y      = 3'd3,
		REG_PLANE_X    = 3'd4,
		REG_PLANE_Y    = 3'd5,
		REG_PITCH      = 3'd6,
		REG_EYE_HEIGHT = 3'd7
	} fct_reg_t;

	typedef struct packed {
		logic       surface;
		logic [8:0] row;
		logic [9:0] column;
	} fct_in_t;

	typedef struct packed {
		logic       draw;
		logic [8:0] frame_row;
		logic [9:0] frame_col;
		logic [5:0] texel_u;
		logic [5:0] texel_v;
	} fct_out_t;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic div_cap;
		logic mul_x;
		logic mul_y;
		logic rcp_mul;
		logic cap_sx;
		logic cap_sy;
		logic emit;
	} fct_cmd_t;

	typedef struct packed {
		logic setup;
		logic out_free;
		logic div_done;
		logic div_busy;
	} fct_stat_t;

endpackage

// ===== src/floor_ceiling_texel_caster.sv =====
// Top level of the floor and ceiling texel caster.
// Usage: pixel requests (surface, row, column) enter on in_valid/in_stall in
// raster order; each gives one result (draw, frame_row, frame_col, texel_u,
// texel_v) on out_valid/out_stall. Column 0 of a drawable row triggers the row setup.
// Sequence: a pixel is taken in, then issued into the result register; a new
// request is taken only after the last result is issued. A column 0 pixel of
// a drawable row first runs the row setup: start and the passes of the
// bit-serial divider for the row distance, capture, two multiply steps,
// reciprocal multiplication by the screen width for the x and y world steps
// and their capture, then issue.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, write only while idle.
// Reset: view registers take their defaults, the world walk and row state
// clear, no result is pending and intake is open.
// Stall: a result waits in the output register while out_stall is high; the
// next request is taken meanwhile and holds in the controller until the
// register frees.
module floor_ceiling_texel_caster import fct_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int TEX_SIZE      = TEX_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  fct_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fct_out_t              out_data
);

	fct_cmd_t  cmd;
	fct_stat_t st;

	assign cfg_ready = 1'b1;

	fct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	fct_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TEX_SIZE      (TEX_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.st        (st)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while intake stays open");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result issued over a held result");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy)
		else $error("divider started while busy");

endmodule

// ===== src/fct_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module fct_divider import fct_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/fct_datapath.sv =====
// Datapath: configuration, row setup arithmetic, world point walk and result register.
module fct_datapath import fct_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int TEX_SIZE      = TEX_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  fct_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fct_out_t              out_data,
	input  fct_cmd_t              cmd,
	output fct_stat_t             st
);

	localparam int HALF   = SCREEN_HEIGHT / 2;
	localparam int TEX_B  = $clog2(TEX_SIZE);
	localparam int MAG_W  = 30;
	localparam int RCP_W  = MAG_W + 1;
	localparam int SW_B   = $clog2(SCREEN_WIDTH);
	localparam int RCP_K  = MAG_W + SW_B;
	localparam logic [63:0] RCP_M =
		((64'd1 << RCP_K) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH);

	logic [23:0]        pos_x_q, pos_y_q;
	logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic signed [9:0]  pitch_q;
	logic signed [8:0]  eye_q;

	fct_in_t req_q;

	logic signed [WORLD_W-1:0] point_x_q, point_y_q, step_x_q, step_y_q;
	logic                      row_valid_q;
	logic signed [DIST_W-1:0]  dist_q;
	logic signed [47:0]        prod_s_q;
	logic signed [48:0]        prod_p_q;
	logic                      rcp_neg_q;
	logic [MAG_W-1:0]          rcp_mag_q;
	logic [MAG_W+RCP_W-1:0]    rcp_prod_q;

	fct_out_t out_q;
	logic     out_valid_q;

	logic signed [OFS_W-1:0] look;
	logic signed [OFS_W-1:0] row_ofs;
	logic signed [OFS_W-1:0] offset;
	logic signed [OFS_W-1:0] depth;
	logic [OFS_W-1:0]        depth_abs;
	logic                    row_ok;
	logic                    col_oor;
	logic                    col_zero;
	logic                    draw;
	logic signed [32:0]      step_num;
	logic [MAG_W-1:0]        step_abs;
	logic [MAG_W-1:0]        rcp_quo;
	logic [MAG_W-1:0]        rcp_back;
	logic                    rcp_rem_nz;
	logic [DVD_W-1:0]        dvd;
	logic [DVS_W-1:0]        dvs;
	logic                    div_busy, div_done;
	logic [DVD_W-1:0]        quo;
	logic signed [WORLD_W-1:0] step_res;
	logic signed [WORLD_W-1:0] point_res;
	logic signed [17:0]      plane_sel;
	logic signed [18:0]      diff_sel;

	function automatic logic [5:0] texel_of(input logic [WORLD_W-1:0] p);
		logic [15:0] frac;
		logic [15:0] mag;
		logic [15:0] t;
		logic [15:0] masked;
		frac   = p[WORLD_W-1] ? 16'(-p[15:0]) : p[15:0];
		mag    = frac >> (FRAC_W - TEX_B);
		t      = p[WORLD_W-1] ? 16'(-mag) : mag;
		masked = t & 16'(TEX_SIZE - 1);
		return masked[5:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			dir_x_q   <= 18'sd65536;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= 18'sd43254;
			pitch_q   <= '0;
			eye_q     <= '0;
		end else if (cfg_valid) begin
			case (fct_reg_t'(cfg_index))
				REG_POS_X:      pos_x_q   <= cfg_data;
				REG_POS_Y:      pos_y_q   <= cfg_data;
				REG_DIR_X:      dir_x_q   <= cfg_data[17:0];
				REG_DIR_Y:      dir_y_q   <= cfg_data[17:0];
				REG_PLANE_X:    plane_x_q <= cfg_data[17:0];
				REG_PLANE_Y:    plane_y_q <= cfg_data[17:0];
				REG_PITCH:      pitch_q   <= cfg_data[9:0];
				REG_EYE_HEIGHT: eye_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign look      = OFS_W'(pitch_q) + OFS_W'(eye_q);
	assign row_ofs   = $signed(OFS_W'(req_q.row)) - OFS_W'(HALF);
	assign offset    = req_q.surface ? row_ofs + look : row_ofs - look;
	assign row_ok    = (offset > 0) && (OFS_W'(req_q.row) < OFS_W'(SCREEN_HEIGHT));
	assign col_oor   = 13'(req_q.column) >= 13'(SCREEN_WIDTH);
	assign col_zero  = req_q.column == '0;
	assign draw      = !col_oor && row_ok && (col_zero || row_valid_q);
	assign depth     = OFS_W'(HALF) + OFS_W'(eye_q);
	assign depth_abs = depth[OFS_W-1] ? OFS_W'(-depth) : depth;

	assign dvd = DVD_W'({depth_abs[11:0], 16'b0});
	assign dvs = DVS_W'(offset);

	fct_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	assign step_num   = $signed(prod_s_q[47:15]);
	assign step_abs   = step_num[32] ? MAG_W'(-step_num) : MAG_W'(step_num);
	assign rcp_quo    = MAG_W'(rcp_prod_q >> RCP_K);
	assign rcp_back   = rcp_quo * MAG_W'(SCREEN_WIDTH);
	assign rcp_rem_nz = rcp_back != rcp_mag_q;

	assign step_res  = rcp_neg_q ?
	                   -(WORLD_W'(rcp_quo) + WORLD_W'(rcp_rem_nz)) : WORLD_W'(rcp_quo);
	assign point_res = WORLD_W'($signed(prod_p_q[48:16]));

	assign plane_sel = cmd.mul_y ? plane_y_q : plane_x_q;
	assign diff_sel  = cmd.mul_y ? 19'(dir_y_q) - 19'(plane_y_q) :
	                               19'(dir_x_q) - 19'(plane_x_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			req_q <= in_data;
		if (cmd.div_cap)
			dist_q <= depth[OFS_W-1] ? -DIST_W'(quo[28:0]) : DIST_W'(quo[28:0]);
		if (cmd.mul_x || cmd.mul_y) begin
			prod_s_q <= 48'(dist_q) * 48'(plane_sel);
			prod_p_q <= 49'(dist_q) * 49'(diff_sel);
		end
		if (cmd.rcp_mul) begin
			rcp_neg_q  <= step_num[32];
			rcp_mag_q  <= step_abs;
			rcp_prod_q <= step_abs * RCP_M[RCP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q   <= '0;
			point_y_q   <= '0;
			step_x_q    <= '0;
			step_y_q    <= '0;
			row_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mul_y)
				point_x_q <= WORLD_W'(pos_x_q) + point_res;
			if (cmd.cap_sx) begin
				step_x_q  <= step_res;
				point_y_q <= WORLD_W'(pos_y_q) + point_res;
			end
			if (cmd.cap_sy) begin
				step_y_q    <= step_res;
				row_valid_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (draw) begin
					point_x_q <= point_x_q + step_x_q;
					point_y_q <= point_y_q + step_y_q;
				end
				if (col_zero && !row_ok)
					row_valid_q <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.draw      <= draw;
			out_q.frame_row <= !draw ? '0 :
			                   req_q.surface ? 9'(SCREEN_HEIGHT - 1 - int'(req_q.row)) :
			                   req_q.row;
			out_q.frame_col <= draw ? req_q.column : '0;
			out_q.texel_u   <= draw ? texel_of(point_x_q) : '0;
			out_q.texel_v   <= draw ? texel_of(point_y_q) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign st.setup    = col_zero && row_ok;
	assign st.out_free = !out_valid_q || !out_stall;
	assign st.div_done = div_done;
	assign st.div_busy = div_busy;

endmodule

// ===== src/fct_ctrl.sv =====
// Controller state machine: request intake, row setup sequence and result issue.
module fct_ctrl import fct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  fct_stat_t st,
	output fct_cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_CHECK = 8'b00000010,
		ST_DDIST = 8'b00000100,
		ST_MULX  = 8'b00001000,
		ST_MULY  = 8'b00010000,
		ST_DSX   = 8'b00100000,
		ST_DSY   = 8'b01000000,
		ST_FINAL = 8'b10000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (st.setup) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DDIST;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_DDIST: begin
				if (st.div_done) begin
					cmd.div_cap = 1'b1;
					state_d     = ST_MULX;
				end
			end
			ST_MULX: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_MULY;
			end
			ST_MULY: begin
				cmd.mul_y   = 1'b1;
				cmd.rcp_mul = 1'b1;
				state_d     = ST_DSX;
			end
			ST_DSX: begin
				cmd.cap_sx  = 1'b1;
				cmd.rcp_mul = 1'b1;
				state_d     = ST_DSY;
			end
			ST_DSY: begin
				cmd.cap_sy = 1'b1;
				state_d    = ST_FINAL;
			end
			ST_FINAL: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = state_q != ST_IDLE;

endmodule
